### rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared widths and constants for the checked frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // byte and value widths
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;

  // frame layout
  localparam logic [BYTE_W-1:0] HEADER_BYTE       = 8'hAA;
  localparam int                PAYLOAD_BYTES_DEF = 8;
  localparam int                VALUE_COUNT       = 4;

  // payload bytes that feed the held values
  localparam int VALUE_BYTES = 2 * VALUE_COUNT;

endpackage

### rtl/cfr_if.sv
// ----------------------------------------------------------------------------
// cfr_in_if / cfr_out_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface cfr_in_if
  import cfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if
  import cfr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      frame_ok;
  logic signed [VALUE_W-1:0] value_a;
  logic signed [VALUE_W-1:0] value_b;
  logic signed [VALUE_W-1:0] value_c;
  logic signed [VALUE_W-1:0] value_d;

  modport source (output valid, output frame_ok, output value_a, output value_b,
                  output value_c, output value_d, input ready);
  modport sink   (input valid, input frame_ok, input value_a, input value_b,
                  input value_c, input value_d, output ready);
endinterface

### rtl/checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// checked_frame_receiver
// Deframer with running sum and add checks, holding four 16-bit values.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle and follows a frame of header
// 0xAA, a length byte equal to PAYLOAD_BYTES, the payload, a sum check byte
// and an add check byte. Every byte is absorbed in the cycle it is accepted
// by the position counter and the two running sums. The add check byte loads
// the result register, so a result is offered in the cycle after the last byte
// of a frame; the four values are updated only when both checks match and
// are repeated otherwise. Input is stalled only when the add check byte
// arrives while the previous result is still waiting to be taken.
module checked_frame_receiver
  import cfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cfr_in_if.sink    in_ch,
  cfr_out_if.source out_ch
);

  localparam int POS_W       = $clog2(PAYLOAD_BYTES + 4);
  localparam int STORE_BYTES = (PAYLOAD_BYTES < VALUE_BYTES) ? PAYLOAD_BYTES : VALUE_BYTES;
  localparam logic [BYTE_W-1:0] LEN_BYTE = BYTE_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0]  POS_IDLE = '0;
  localparam logic [POS_W-1:0]  POS_LEN  = POS_W'(1);
  localparam logic [POS_W-1:0]  POS_SUM  = POS_W'(PAYLOAD_BYTES + 2);
  localparam logic [POS_W-1:0]  POS_ADD  = POS_W'(PAYLOAD_BYTES + 3);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0]  sos_r, sos_nxt;
  logic               sum_ok_r, sum_ok_nxt;
  logic [BYTE_W-1:0]  store_r [STORE_BYTES];
  logic [VALUE_W-1:0] held_r [VALUE_COUNT];
  logic               out_valid_r, out_valid_nxt;
  logic               frame_ok_r;
  logic               in_acc;
  logic [BYTE_W-1:0]  rx_b;
  logic [BYTE_W-1:0]  acc_sum;
  logic               in_payload;
  logic [POS_W-1:0]   wr_idx;
  logic               frame_good;
  logic               final_acc;

  assign rx_b = in_ch.rx_byte;

  // stall only the last byte of a frame while a result is still waiting
  assign in_ch.ready = !((pos_r == POS_ADD) && out_valid_r && !out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign acc_sum    = sum_r + rx_b;
  assign in_payload = (pos_r > POS_LEN) && (pos_r < POS_SUM);
  assign wr_idx     = pos_r - POS_W'(2);
  assign frame_good = sum_ok_r && (rx_b == sos_r);
  assign final_acc  = in_acc && (pos_r == POS_ADD);

  // frame position and running checks
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    sos_nxt    = sos_r;
    sum_ok_nxt = sum_ok_r;
    if (in_acc) begin
      if (pos_r == POS_IDLE) begin
        if (rx_b == HEADER_BYTE) begin
          sum_nxt = rx_b;
          sos_nxt = rx_b;
          pos_nxt = POS_LEN;
        end
      end else if (pos_r == POS_LEN) begin
        if (rx_b == LEN_BYTE) begin
          sum_nxt = acc_sum;
          sos_nxt = sos_r + acc_sum;
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pos_nxt    = POS_IDLE;
          sum_nxt    = '0;
          sos_nxt    = '0;
          sum_ok_nxt = 1'b0;
        end
      end else if (in_payload) begin
        sum_nxt = acc_sum;
        sos_nxt = sos_r + acc_sum;
        pos_nxt = pos_r + POS_W'(1);
      end else if (pos_r == POS_SUM) begin
        sum_ok_nxt = (rx_b == sum_r);
        pos_nxt    = POS_ADD;
      end else begin
        pos_nxt    = POS_IDLE;
        sum_nxt    = '0;
        sos_nxt    = '0;
        sum_ok_nxt = 1'b0;
      end
    end
  end

  // result handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (final_acc) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_IDLE;
      sum_r       <= '0;
      sos_r       <= '0;
      sum_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      sos_r       <= sos_nxt;
      sum_ok_r    <= sum_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload bytes that feed a value
  always_ff @(posedge clk) begin
    for (int k = 0; k < STORE_BYTES; k++) begin
      if (in_acc && in_payload && (wr_idx == POS_W'(k))) begin
        store_r[k] <= rx_b;
      end
    end
  end

  // result flag
  always_ff @(posedge clk) begin
    if (final_acc) begin
      frame_ok_r <= frame_good;
    end
  end

  // held values, updated from complete byte pairs on a good frame
  for (genvar i = 0; i < VALUE_COUNT; i++) begin : g_value
    if (2 * i + 1 < STORE_BYTES) begin : g_live
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          held_r[i] <= '0;
        end else if (final_acc && frame_good) begin
          held_r[i] <= {store_r[2*i+1], store_r[2*i]};
        end
      end
    end else begin : g_fixed
      always_ff @(posedge clk) begin
        held_r[i] <= '0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.frame_ok = frame_ok_r;
  assign out_ch.value_a  = held_r[0];
  assign out_ch.value_b  = held_r[1];
  assign out_ch.value_c  = held_r[2];
  assign out_ch.value_d  = held_r[3];

  // position never runs past the add check byte
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_ADD)
    else $error("frame position out of range");

  // the add check byte always produces a result
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    final_acc |=> (out_valid_r && pos_r == POS_IDLE))
    else $error("final byte gave no result");

  // a new result only appears after a final byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (pos_r == POS_IDLE && $past(final_acc)))
    else $error("result without final byte");

  // a good frame needs a matched sum check
  a_ok_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (final_acc && frame_good) |-> sum_ok_r)
    else $error("frame ok without sum check");

endmodule

### bench/checked_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_frame_receiver_tb
// Feeds received bytes into the deframer: a few hand-picked frames first,
// then random frames, broken frames and line noise. A predictor follows
// each accepted byte and queues the frame result it should produce. Every
// result item is compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module checked_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int PAYLOAD_BYTES  = PAYLOAD_BYTES_DEF;
  localparam int FRAME_BYTES    = PAYLOAD_BYTES + 4;
  localparam int POS_HEADER     = 0;
  localparam int POS_LENGTH     = 1;
  localparam int POS_PAYLOAD    = 2;
  localparam int POS_SUM        = PAYLOAD_BYTES + 2;
  localparam int TARGET_BYTES   = 1650;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                                frame_ok;
    logic [VALUE_COUNT-1:0][VALUE_W-1:0] values;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  checked_frame_receiver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [BYTE_W-1:0] rx_bytes_queued[$];
  frame_result_t     frame_results_due[$];

  int in_count    = 0;
  int total_bytes = 0;
  int phase_len   = 0;
  int hold_at     = 0;
  int idle_cycles = 0;
  int fail_count  = 0;
  int result_idx  = 0;
  int send_idle_pct;
  int take_stall_pct;

  // predictor state
  int                 frame_pos       = POS_HEADER;
  logic [BYTE_W-1:0]  sum_acc         = '0;
  logic [BYTE_W-1:0]  sum_of_sums_acc = '0;
  logic               sum_good        = 1'b0;
  logic [BYTE_W-1:0]  payload_seen[PAYLOAD_BYTES];
  logic [VALUE_W-1:0] held_values[VALUE_COUNT] = '{default: '0};

  // idling phases: sender light / receiver heavy, then swapped, then none
  assign send_idle_pct  = (in_count < phase_len) ? 13 :
                          (in_count < 2 * phase_len) ? 72 : 0;
  assign take_stall_pct = (in_count < phase_len) ? 72 :
                          (in_count < 2 * phase_len) ? 13 : 0;

  // follow one accepted byte through the frame layout
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    frame_result_t res;
    logic          ok;
    if (frame_pos == POS_HEADER) begin
      if (b == HEADER_BYTE) begin
        sum_acc         = b;
        sum_of_sums_acc = b;
        frame_pos       = POS_LENGTH;
      end
    end else if (frame_pos == POS_LENGTH) begin
      if (b == 8'(PAYLOAD_BYTES)) begin
        sum_acc         = sum_acc + b;
        sum_of_sums_acc = sum_of_sums_acc + sum_acc;
        frame_pos       = POS_PAYLOAD;
      end else begin
        frame_pos = POS_HEADER;
      end
    end else if (frame_pos < POS_SUM) begin
      payload_seen[frame_pos - POS_PAYLOAD] = b;
      sum_acc         = sum_acc + b;
      sum_of_sums_acc = sum_of_sums_acc + sum_acc;
      frame_pos       = frame_pos + 1;
    end else if (frame_pos == POS_SUM) begin
      sum_good  = (b == sum_acc);
      frame_pos = frame_pos + 1;
    end else begin
      // add check byte closes the frame
      ok = sum_good && (b == sum_of_sums_acc);
      if (ok) begin
        for (int i = 0; i < VALUE_COUNT; i++) begin
          if (2 * i + 1 < PAYLOAD_BYTES)
            held_values[i] = {payload_seen[2 * i + 1], payload_seen[2 * i]};
        end
      end
      res.frame_ok = ok;
      for (int i = 0; i < VALUE_COUNT; i++)
        res.values[i] = held_values[i];
      frame_results_due.push_back(res);
      frame_pos = POS_HEADER;
      sum_good  = 1'b0;
    end
  endtask

  // payload with a bias towards zero, minus one and the extremes of a signed 16-bit value
  function automatic logic [8*PAYLOAD_BYTES-1:0] random_payload();
    logic [8*PAYLOAD_BYTES-1:0] p;
    for (int i = 0; i < PAYLOAD_BYTES; i += 2) begin
      case ($urandom_range(0, 7))
        0: p[8*i +: 16] = 16'h0000;
        1: p[8*i +: 16] = 16'hFFFF;
        2: p[8*i +: 16] = 16'h8000;
        3: p[8*i +: 16] = 16'h7FFF;
        default: p[8*i +: 16] = 16'($urandom);
      endcase
    end
    return p;
  endfunction

  // append a whole frame, optionally spoiling either check byte
  task automatic queue_frame(input logic [8*PAYLOAD_BYTES-1:0] payload,
                             input logic [BYTE_W-1:0] len,
                             input bit spoil_sum, input bit spoil_add);
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] ss;
    s  = HEADER_BYTE;
    ss = s;
    rx_bytes_queued.push_back(HEADER_BYTE);
    rx_bytes_queued.push_back(len);
    s  = s + len;
    ss = ss + s;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      rx_bytes_queued.push_back(payload[8*i +: 8]);
      s  = s + payload[8*i +: 8];
      ss = ss + s;
    end
    if (spoil_sum) s = s ^ 8'($urandom_range(1, 255));
    if (spoil_add) ss = ss ^ 8'($urandom_range(1, 255));
    rx_bytes_queued.push_back(s);
    rx_bytes_queued.push_back(ss);
  endtask

  // byte sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte);
        in_count <= in_count + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_bytes_queued.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= rx_bytes_queued.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!hold_done && in_count >= hold_at) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    frame_result_t seen;
    frame_result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.frame_ok  = out_ch.frame_ok;
      seen.values[0] = out_ch.value_a;
      seen.values[1] = out_ch.value_b;
      seen.values[2] = out_ch.value_c;
      seen.values[3] = out_ch.value_d;
      if (frame_results_due.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
          $display("result %0d: unexpected item ok=%0b a=%0d b=%0d c=%0d d=%0d",
                   result_idx, seen.frame_ok, $signed(seen.values[0]),
                   $signed(seen.values[1]), $signed(seen.values[2]),
                   $signed(seen.values[3]));
      end else begin
        due = frame_results_due.pop_front();
        if (seen !== due) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d: expected ok=%0b a=%0d b=%0d c=%0d d=%0d",
                     result_idx, due.frame_ok, $signed(due.values[0]),
                     $signed(due.values[1]), $signed(due.values[2]),
                     $signed(due.values[3]));
            $display("result %0d: got      ok=%0b a=%0d b=%0d c=%0d d=%0d",
                     result_idx, seen.frame_ok, $signed(seen.values[0]),
                     $signed(seen.values[1]), $signed(seen.values[2]),
                     $signed(seen.values[3]));
          end
        end
      end
      result_idx = result_idx + 1;
    end
  end

  // cycles without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // stimulus and end of run
  initial begin
    int                pick;
    int                start_size;
    int                counted;
    logic [BYTE_W-1:0] len;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;

    // line noise that is not a header
    rx_bytes_queued.push_back(8'h00);
    rx_bytes_queued.push_back(8'hFF);
    // header byte as a bad length: dropped, not taken as a new header
    rx_bytes_queued.push_back(HEADER_BYTE);
    rx_bytes_queued.push_back(HEADER_BYTE);
    // good frame with zero, minus one, most negative and most positive values
    queue_frame({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 8'(PAYLOAD_BYTES), 1'b0, 1'b0);
    // bad sum check: previous values repeated
    queue_frame(random_payload(), 8'(PAYLOAD_BYTES), 1'b1, 1'b0);

    // random frames, mostly well formed
    counted = 0;
    while (counted < TARGET_BYTES) begin
      pick       = $urandom_range(0, 99);
      start_size = rx_bytes_queued.size();
      if (pick < 66) begin
        queue_frame(random_payload(), 8'(PAYLOAD_BYTES), 1'b0, 1'b0);
      end else if (pick < 74) begin
        queue_frame(random_payload(), 8'(PAYLOAD_BYTES), 1'b1, 1'b0);
      end else if (pick < 82) begin
        queue_frame(random_payload(), 8'(PAYLOAD_BYTES), 1'b0, 1'b1);
      end else if (pick < 86) begin
        queue_frame(random_payload(), 8'(PAYLOAD_BYTES), 1'b1, 1'b1);
      end else if (pick < 91) begin
        do len = 8'($urandom_range(0, 255)); while (len == 8'(PAYLOAD_BYTES));
        queue_frame(random_payload(), len, 1'b0, 1'b0);
      end else if (pick < 95) begin
        // frame cut short, the next bytes run on into it
        queue_frame(random_payload(), 8'(PAYLOAD_BYTES), 1'b0, 1'b0);
        repeat ($urandom_range(1, FRAME_BYTES - 1)) void'(rx_bytes_queued.pop_back());
      end else begin
        repeat ($urandom_range(1, 4)) rx_bytes_queued.push_back(8'($urandom_range(0, 255)));
      end
      if (pick < 95) counted = counted + rx_bytes_queued.size() - start_size;
    end

    total_bytes = rx_bytes_queued.size();
    phase_len   = total_bytes / 3;
    hold_at     = 2 * phase_len + 40;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (in_count < total_bytes && idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    while (frame_results_due.size() > 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT)
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
    fail_count = fail_count + frame_results_due.size();
    if (idle_cycles < WATCHDOG_LIMIT && fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
